FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and codes of the bounded stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsp_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int OP_W      = 3;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 4;
    localparam int STAT_W    = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CHANGE = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVER  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDER = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_ROT,
        CELL_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

endpackage

FILE: design/bsp_in_if.sv
// ----------------------------------------------------------------------------
// bsp_in_if
// Command channel: opcode, value and position with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsp_in_if;
    import bsp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, output opcode, output value, output position, input ready);
    modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

FILE: design/bsp_out_if.sv
// ----------------------------------------------------------------------------
// bsp_out_if
// Result channel: status, data and last with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsp_out_if;
    import bsp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] data;
    logic                     last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

FILE: design/bsp_cell.sv
// ----------------------------------------------------------------------------
// bsp_cell
// One stack slot; IDX 0 is the top. Shifts from neighbors, rotates, or loads i_value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsp_cell #(
    parameter int DEPTH = bsp_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                             i_clk,
    input  bsp_pkg::t_cell_ctl               i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]       i_cnt_m1,
    input  logic signed [bsp_pkg::WORD_W-1:0] i_value,
    input  logic signed [bsp_pkg::WORD_W-1:0] i_above,
    input  logic signed [bsp_pkg::WORD_W-1:0] i_below,
    input  logic signed [bsp_pkg::WORD_W-1:0] i_top,
    output logic signed [bsp_pkg::WORD_W-1:0] o_word
);
    import bsp_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;
    logic [POS_W-1:0]         w_pos_m1;
    logic                     w_hit;
    logic                     w_wrap;

    assign w_pos_m1 = i_ctl.pos - POS_W'(1);
    assign w_hit    = (CMP_W'(w_pos_m1) == CMP_W'(IDX));
    assign w_wrap   = (CMP_W'(i_cnt_m1) == CMP_W'(IDX));

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            CELL_PUSH:  n_word = i_above;
            CELL_POP:   n_word = i_below;
            CELL_ROT:   n_word = w_wrap ? i_top : i_below;
            CELL_WRITE: n_word = w_hit ? i_value : r_word;
            default:    n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
endmodule

FILE: design/bounded_stack_with_peek_and_change.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_peek_and_change
// LIFO stack of signed words built as a chain of cells, with peek and change.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries one command beat: opcode, value, position (1 is the top).
//   o_out carries result beats: status, data, last (last marks the final
//   beat of a command).
//   Push, pop and peek: one result beat, registered, in the cycle after the
//   command beat; a new command is taken every cycle while o_out flows.
//   Dump and a valid change: count result beats, one per cycle while o_out
//   flows, from the top down; i_in is held off until the last beat is
//   loaded. Listing rotates the occupied cells one step per beat; after
//   count steps the stack is back in order.
//   Errors (overflow, underflow, bad position, empty dump) give one beat.
//   Unused opcodes are taken and give no beat.
//   Reset (i_rst_n low, synchronous) empties the stack and drops any
//   pending result. While a result is pending and o_out.ready is low the
//   result register holds and i_in is not ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bounded_stack_with_peek_and_change #(
    parameter int DEPTH = bsp_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsp_in_if.sink    i_in,
    bsp_out_if.source o_out
);
    import bsp_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
    localparam int NSEL  = (DEPTH < 15) ? DEPTH : 15;

    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CW-1:0]            r_rem;
    logic [CW-1:0]            n_rem;
    logic                     r_out_valid;
    logic [STAT_W-1:0]        r_status;
    logic signed [WORD_W-1:0] r_data;
    logic                     r_last;

    logic signed [WORD_W-1:0] w_cell [DEPTH];
    logic signed [WORD_W-1:0] w_sel;
    logic [POS_W-1:0]         w_pos_m1;
    t_cell_ctl                w_ctl;
    logic                     w_slot;
    logic                     w_acc;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_pos_ok;
    logic                     w_load;
    logic [STAT_W-1:0]        w_status;
    logic signed [WORD_W-1:0] w_data;
    logic                     w_last;

    assign w_slot   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_slot;
    assign w_acc    = i_in.valid && i_in.ready;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_pos_ok = (i_in.position != '0) &&
                      (CMP_W'(i_in.position) <= CMP_W'(r_count));
    assign w_pos_m1 = i_in.position - POS_W'(1);

    always_comb begin
        w_sel = '0;
        for (int k = 0; k < NSEL; k++) begin
            if (w_pos_m1 == POS_W'(k)) begin
                w_sel = w_cell[k];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bsp_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_cnt_m1 (r_count - CW'(1)),
            .i_value  (i_in.value),
            .i_above  ((g == 0) ? i_in.value : w_cell[(g == 0) ? 0 : g - 1]),
            .i_below  (w_cell[(g == DEPTH - 1) ? g : g + 1]),
            .i_top    (w_cell[0]),
            .o_word   (w_cell[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && (((i_in.opcode == OP_CHANGE) && w_pos_ok) ||
                              ((i_in.opcode == OP_DUMP) && !w_empty))) begin
                    n_state = S_LIST;
                end
            end
            S_LIST: begin
                if (w_slot && (r_rem == CW'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl.op  = CELL_HOLD;
        w_ctl.pos = i_in.position;
        w_load    = 1'b0;
        w_status  = STAT_OK;
        w_data    = '0;
        w_last    = 1'b1;
        n_count   = r_count;
        n_rem     = r_rem;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_in.opcode)
                        OP_PUSH: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                w_status = STAT_OVER;
                            end else begin
                                w_ctl.op = CELL_PUSH;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_POP: begin
                            w_load = 1'b1;
                            if (w_empty) begin
                                w_status = STAT_UNDER;
                            end else begin
                                w_ctl.op = CELL_POP;
                                n_count  = r_count - CW'(1);
                                w_data   = w_cell[0];
                            end
                        end
                        OP_PEEK: begin
                            w_load = 1'b1;
                            if (w_pos_ok) begin
                                w_data = w_sel;
                            end else begin
                                w_status = STAT_UNDER;
                            end
                        end
                        OP_CHANGE: begin
                            if (w_pos_ok) begin
                                w_ctl.op = CELL_WRITE;
                                n_rem    = r_count;
                            end else begin
                                w_load   = 1'b1;
                                w_status = STAT_UNDER;
                            end
                        end
                        OP_DUMP: begin
                            if (w_empty) begin
                                w_load   = 1'b1;
                                w_status = STAT_UNDER;
                            end else begin
                                n_rem = r_count;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LIST: begin
                if (w_slot) begin
                    w_load   = 1'b1;
                    w_data   = w_cell[0];
                    w_last   = (r_rem == CW'(1));
                    w_ctl.op = CELL_ROT;
                    n_rem    = r_rem - CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rem   <= n_rem;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= w_status;
            r_data   <= w_data;
            r_last   <= w_last;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_status;
    assign o_out.data   = r_data;
    assign o_out.last   = r_last;

    `BSP_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count over depth")
    `BSP_ASSERT_IMP(a_list_rem, i_clk, i_rst_n, r_state == S_LIST, (r_rem != '0) && (r_rem <= r_count), "listing counter out of range")
    `BSP_ASSERT_NXT(a_push_count, i_clk, i_rst_n, w_acc && (i_in.opcode == OP_PUSH) && !w_full, r_count == $past(r_count) + CW'(1), "push did not grow stack")
endmodule

FILE: verif/tb_bounded_stack_with_peek_and_change.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_stack_with_peek_and_change
// Self-checking bench for the bounded stack with peek and change.
// ----------------------------------------------------------------------------
// A queue of commands feeds a clocked driver. At each accepted command beat
// the bench's own stack model works out the result beats. A clocked monitor
// pops them in order and compares status, data and last on every result beat.
// A short directed run fills the stack, overflows it, peeks and changes at
// good and bad positions, lists it, and drains it into underflow. Random
// command streams then run under four flow-control phases.
// ----------------------------------------------------------------------------

module tb_bounded_stack_with_peek_and_change;
    import bsp_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [OP_W-1:0]          opcode;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
        bit                       wait_drain;
    } t_stack_cmd;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] data;
        logic                     last;
    } t_result_beat;

    logic i_clk;
    logic i_rst_n;

    bsp_in_if  cmd_if ();
    bsp_out_if rsp_if ();

    bounded_stack_with_peek_and_change #(
        .DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (rsp_if)
    );

    // Model state.
    logic signed [WORD_W-1:0] stack_words [STACK_DEPTH];
    int                       stack_count;

    t_stack_cmd   pending_cmds [$];
    t_result_beat expected_beats [$];

    t_stack_cmd drv_cur;
    int         gen_depth;
    int         send_idle_pct;
    int         recv_stall_pct;

    int n_errors;
    int n_cmds;
    int n_predicted;
    int n_checked;
    int n_beats;
    int n_overflows;
    int n_underflows;
    int n_listings;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (n_errors < MAX_PRINTED) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        n_errors++;
    endtask

    task automatic expect_beat(input logic [STAT_W-1:0] status,
                               input logic signed [WORD_W-1:0] data,
                               input logic last);
        t_result_beat b;
        b.status = status;
        b.data   = data;
        b.last   = last;
        expected_beats.push_back(b);
        n_predicted++;
        if (status == STAT_OVER) begin
            n_overflows++;
        end
        if (status == STAT_UNDER) begin
            n_underflows++;
        end
    endtask

    task automatic list_stack_words();
        if (stack_count == 0) begin
            expect_beat(STAT_UNDER, '0, 1'b1);
        end else begin
            n_listings++;
            for (int i = stack_count; i > 0; i--) begin
                expect_beat(STAT_OK, stack_words[i-1], i == 1);
            end
        end
    endtask

    task automatic predict_stack_op(input t_stack_cmd c);
        bit pos_ok;
        pos_ok = (c.position != 0) && (int'(c.position) <= stack_count);
        case (c.opcode)
            OP_PUSH: begin
                if (stack_count >= STACK_DEPTH) begin
                    expect_beat(STAT_OVER, '0, 1'b1);
                end else begin
                    stack_words[stack_count] = c.value;
                    stack_count++;
                    expect_beat(STAT_OK, '0, 1'b1);
                end
            end
            OP_POP: begin
                if (stack_count == 0) begin
                    expect_beat(STAT_UNDER, '0, 1'b1);
                end else begin
                    stack_count--;
                    expect_beat(STAT_OK, stack_words[stack_count], 1'b1);
                end
            end
            OP_PEEK: begin
                if (!pos_ok) begin
                    expect_beat(STAT_UNDER, '0, 1'b1);
                end else begin
                    expect_beat(STAT_OK, stack_words[stack_count - c.position], 1'b1);
                end
            end
            OP_CHANGE: begin
                if (!pos_ok) begin
                    expect_beat(STAT_UNDER, '0, 1'b1);
                end else begin
                    stack_words[stack_count - c.position] = c.value;
                    list_stack_words();
                end
            end
            OP_DUMP: begin
                list_stack_words();
            end
            default: begin
            end
        endcase
    endtask

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                predict_stack_op(drv_cur);
                n_cmds++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (pending_cmds.size() != 0 &&
                    !(pending_cmds[0].wait_drain && n_predicted != n_checked) &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                    drv_cur = pending_cmds.pop_front();
                    cmd_if.valid    <= 1'b1;
                    cmd_if.opcode   <= drv_cur.opcode;
                    cmd_if.value    <= drv_cur.value;
                    cmd_if.position <= drv_cur.position;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_beats++;
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat status=%0d data=%0d last=%0b",
                                              rsp_if.status, rsp_if.data, rsp_if.last));
                end else begin
                    t_result_beat exp_b;
                    exp_b = expected_beats.pop_front();
                    if (rsp_if.status !== exp_b.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_if.status, exp_b.status));
                    end
                    if (rsp_if.data !== exp_b.data) begin
                        report_mismatch($sformatf("data %0d, expected %0d",
                                                  rsp_if.data, exp_b.data));
                    end
                    if (rsp_if.last !== exp_b.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  rsp_if.last, exp_b.last));
                    end
                    n_checked <= n_checked + 1;
                end
            end
            rsp_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic queue_cmd(input logic [OP_W-1:0] opcode,
                             input logic signed [WORD_W-1:0] value,
                             input logic [POS_W-1:0] position,
                             input bit wait_drain);
        t_stack_cmd c;
        c.opcode     = opcode;
        c.value      = value;
        c.position   = position;
        c.wait_drain = wait_drain;
        pending_cmds.push_back(c);
        if (opcode == OP_PUSH && gen_depth < STACK_DEPTH) begin
            gen_depth++;
        end
        if (opcode == OP_POP && gen_depth > 0) begin
            gen_depth--;
        end
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        if ($urandom_range(9, 0) != 0) begin
            return $urandom;
        end
        case ($urandom_range(3, 0))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            default: return -32'sd1;
        endcase
    endfunction

    // Mostly legal positions around the current depth, some of the full range.
    task automatic queue_random(input int n);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        int               r;
        int               push_lim;
        for (int i = 0; i < n; i++) begin
            r        = $urandom_range(99, 0);
            push_lim = 44 - 3 * gen_depth;
            if (r >= 95) begin
                op = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
            end else if (r < push_lim) begin
                op = OP_PUSH;
            end else if (r < push_lim + 15) begin
                op = OP_PEEK;
            end else if (r < push_lim + 25) begin
                op = OP_CHANGE;
            end else if (r < push_lim + 31) begin
                op = OP_DUMP;
            end else begin
                op = OP_POP;
            end
            if (gen_depth > 0 && $urandom_range(9, 0) < 8) begin
                pos = POS_W'($urandom_range(gen_depth, 1));
            end else begin
                pos = POS_W'($urandom_range(15, 0));
            end
            queue_cmd(op, pick_word(), pos, (i % 40) == 39);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        @(negedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random(n);
        while (pending_cmds.size() != 0 || cmd_if.valid || n_predicted != n_checked) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.opcode   = OP_PUSH;
        cmd_if.value    = '0;
        cmd_if.position = '0;
        rsp_if.ready    = 1'b0;
        stack_count     = 0;
        gen_depth       = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        n_errors        = 0;
        n_cmds          = 0;
        n_predicted     = 0;
        n_checked       = 0;
        n_beats         = 0;
        n_overflows     = 0;
        n_underflows    = 0;
        n_listings      = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill with extremes, overflow, bad and good positions, list, drain.
        queue_cmd(OP_PUSH, 32'sh8000_0000, 4'd0, 1'b0);
        queue_cmd(OP_PUSH, 32'sh7fff_ffff, 4'd15, 1'b0);
        queue_cmd(OP_PUSH, '0, 4'd0, 1'b0);
        queue_cmd(OP_PUSH, -32'sd1, 4'd0, 1'b0);
        for (int i = 0; i < STACK_DEPTH - 4; i++) begin
            queue_cmd(OP_PUSH, $urandom, 4'd0, 1'b0);
        end
        queue_cmd(OP_PUSH, 32'sh1234_5678, 4'd1, 1'b0);
        queue_cmd(OP_PEEK, '0, POS_W'(STACK_DEPTH), 1'b0);
        queue_cmd(OP_PEEK, '0, 4'd0, 1'b0);
        queue_cmd(OP_CHANGE, 32'sh5a5a_a5a5, 4'd1, 1'b0);
        queue_cmd(OP_CHANGE, 32'sh0bad_0bad, 4'd15, 1'b0);
        queue_cmd(OP_DUMP, -32'sd1, 4'd15, 1'b0);
        queue_cmd(OP_UNUSED_FIRST, '0, 4'd1, 1'b0);
        queue_cmd(OP_UNUSED_LAST, -32'sd1, 4'd15, 1'b0);
        for (int i = 0; i < STACK_DEPTH; i++) begin
            queue_cmd(OP_POP, '0, 4'd0, 1'b0);
        end
        queue_cmd(OP_POP, '0, 4'd0, 1'b0);
        queue_cmd(OP_DUMP, '0, 4'd0, 1'b0);
        queue_cmd(OP_CHANGE, 32'sh7fff_ffff, 4'd1, 1'b1);
        queue_cmd(OP_PEEK, '0, 4'd1, 1'b0);

        run_phase(0, 0, 80);
        run_phase(63, 0, 80);
        run_phase(0, 63, 80);
        run_phase(35, 35, 80);

        repeat (20) @(negedge i_clk);

        $display("Ran %0d commands giving %0d result beats under four flow-control phases:",
                 n_cmds, n_beats);
        $display("  %0d overflows, %0d underflows or bad positions, %0d full listings.",
                 n_overflows, n_underflows, n_listings);
        if (n_errors == 0 && expected_beats.size() == 0) begin
            $display("tb_bounded_stack_with_peek_and_change OK");
        end else begin
            $display("tb_bounded_stack_with_peek_and_change NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d result beats still expected", expected_beats.size());
        $display("tb_bounded_stack_with_peek_and_change NOT OK");
        $finish;
    end

endmodule
